@@ rtl/awb_gain_from_otp_ratios_unit_assert.svh @@
// Assertion macros shared by the white balance gain block.
`ifndef AWB_GAIN_FROM_OTP_RATIOS_UNIT_ASSERT_SVH
`define AWB_GAIN_FROM_OTP_RATIOS_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AWB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("awb assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define AWB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("awb assertion failed");

`endif

@@ rtl/awbg_pkg.sv @@
`timescale 1ns / 1ps
package awbg_pkg;

    localparam int RATIO_W = 10;
    localparam int NUM_W   = 20;
    localparam int GAIN_W  = 16;
    localparam int STEP_W  = 4;
    localparam int P1_STAGES = NUM_W / STEP_W;
    localparam int P2_STAGES = GAIN_W / STEP_W;

    localparam logic [NUM_W-1:0]  RATIO_SCALE = 20'd1000;
    localparam logic [GAIN_W-1:0] UNITY_GAIN  = 16'h0400;
    localparam logic [GAIN_W-1:0] GAIN_MAX    = 16'hFFFF;

    // First division stage data: golden * 1000 / measured for both ratios.
    typedef struct packed {
        logic [1:0][RATIO_W-1:0] rem;
        logic [1:0][NUM_W-1:0]   num;
        logic [1:0][NUM_W-1:0]   quo;
        logic [1:0][RATIO_W-1:0] dvs;
        logic                    fault;
        logic                    missing;
    } p1_t;

    // Second division stage data: three lanes, red, green and blue.
    typedef struct packed {
        logic [2:0][RATIO_W-1:0] rem;
        logic [2:0][GAIN_W-1:0]  num;
        logic [2:0][GAIN_W-1:0]  quo;
        logic [2:0]              ovf;
        logic [RATIO_W-1:0]      base;
        logic                    fault;
        logic                    missing;
    } p2_t;

    // Four steps of restoring division. The remainder stays below the divisor.
    function automatic logic [RATIO_W+STEP_W-1:0] div_step(
        input logic [RATIO_W-1:0] rem,
        input logic [STEP_W-1:0]  bits,
        input logic [RATIO_W-1:0] dvs
    );
        logic [RATIO_W:0]   r;
        logic [RATIO_W-1:0] rr;
        logic [STEP_W-1:0]  q;
        int i;
        rr = rem;
        q  = '0;
        for (i = STEP_W - 1; i >= 0; i--) begin
            r = {rr, bits[i]};
            if (r >= {1'b0, dvs}) begin
                r    = r - {1'b0, dvs};
                q[i] = 1'b1;
            end
            rr = r[RATIO_W-1:0];
        end
        return {rr, q};
    endfunction

endpackage

@@ rtl/awb_gain_from_otp_ratios_unit.sv @@
`timescale 1ns / 1ps
// White balance gain calibration from programmed module ratios.
//
// Input channel (s_valid/s_ready) carries the measured R/G and B/G ratios of
// one camera module and their golden reference values. Output channel
// (m_valid/m_ready) returns red, green and blue gains (0x400 is unity), one
// apply bit per gain above unity, and clip, divide fault and missing golden
// flags. Every transaction in yields exactly one transaction out.
//
// The path holds twelve registers: one input register, five stages of the ratio
// divider (4 quotient bits each), one base select stage, four stages of the gain
// divider (4 quotient bits each), and the output register. The input register
// loads at the accepting edge. Throughput is one transaction per cycle while the
// receiver does not stall, set by the fully pipelined shift-subtract dividers.
//
// Reset clears every valid bit; no transaction is in flight afterwards.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and s_ready drops, so nothing is lost or repeated.
module awb_gain_from_otp_ratios_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [awbg_pkg::RATIO_W-1:0] s_measured_rg,
    input  logic [awbg_pkg::RATIO_W-1:0] s_measured_bg,
    input  logic [awbg_pkg::RATIO_W-1:0] s_golden_rg,
    input  logic [awbg_pkg::RATIO_W-1:0] s_golden_bg,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [awbg_pkg::GAIN_W-1:0] m_red_gain,
    output logic [awbg_pkg::GAIN_W-1:0] m_green_gain,
    output logic [awbg_pkg::GAIN_W-1:0] m_blue_gain,
    output logic                        m_red_apply,
    output logic                        m_green_apply,
    output logic                        m_blue_apply,
    output logic                        m_gain_clipped,
    output logic                        m_divide_fault,
    output logic                        m_golden_missing
);
    import awbg_pkg::*;
    `include "awb_gain_from_otp_ratios_unit_assert.svh"

    logic en;

    logic [P1_STAGES:0] p1_valid_reg;
    p1_t                p1_reg  [P1_STAGES+1];
    p1_t                p1_next [P1_STAGES+1];
    logic [P2_STAGES:0] p2_valid_reg;
    p2_t                p2_reg  [P2_STAGES+1];
    p2_t                p2_next [P2_STAGES+1];

    logic               out_valid_reg;
    logic [2:0][GAIN_W-1:0] gain_reg, gain_next;
    logic [2:0]         apply_reg, apply_next;
    logic               clip_reg, clip_next;
    logic               fault_reg, fault_next;
    logic               missing_reg, missing_next;

    // One enable moves the whole pipeline; it stops only when a result waits.
    assign en      = !out_valid_reg || m_ready;
    assign s_ready = en;

    always_comb begin
        logic [NUM_W-1:0]         nrg, nbg, base_w;
        logic [2:0][NUM_W-1:0]    v;
        logic [RATIO_W+STEP_W-1:0] st;
        logic [2:0]               ovf;
        logic [GAIN_W-1:0]        g;
        int k, j;

        p1_next[0].rem     = '0;
        p1_next[0].quo     = '0;
        p1_next[0].num[0]  = NUM_W'({10'd0, s_golden_rg} * RATIO_SCALE);
        p1_next[0].num[1]  = NUM_W'({10'd0, s_golden_bg} * RATIO_SCALE);
        p1_next[0].dvs[0]  = s_measured_rg;
        p1_next[0].dvs[1]  = s_measured_bg;
        p1_next[0].fault   = (s_measured_rg == '0) || (s_measured_bg == '0);
        p1_next[0].missing = (s_golden_rg == '0) || (s_golden_bg == '0);

        for (k = 1; k <= P1_STAGES; k++) begin
            p1_next[k] = p1_reg[k-1];
            for (j = 0; j < 2; j++) begin
                st = div_step(p1_reg[k-1].rem[j], p1_reg[k-1].num[j][NUM_W-1 -: STEP_W],
                              p1_reg[k-1].dvs[j]);
                p1_next[k].rem[j] = st[RATIO_W+STEP_W-1:STEP_W];
                p1_next[k].quo[j] = {p1_reg[k-1].quo[j][NUM_W-STEP_W-1:0], st[STEP_W-1:0]};
                p1_next[k].num[j] = {p1_reg[k-1].num[j][NUM_W-STEP_W-1:0], {STEP_W{1'b0}}};
            end
        end

        // Base select. The base never exceeds 1000, so it fits the ratio width.
        nrg = p1_reg[P1_STAGES].quo[0];
        nbg = p1_reg[P1_STAGES].quo[1];
        if (nrg < RATIO_SCALE || nbg < RATIO_SCALE) begin
            base_w = (nrg < nbg) ? nrg : nbg;
        end else begin
            base_w = RATIO_SCALE;
        end
        v[0] = nrg;
        v[1] = RATIO_SCALE;
        v[2] = nbg;
        p2_next[0].base    = base_w[RATIO_W-1:0];
        p2_next[0].fault   = p1_reg[P1_STAGES].fault || (base_w == '0);
        p2_next[0].missing = p1_reg[P1_STAGES].missing;
        p2_next[0].quo     = '0;
        // Gain is v * 1024 / base. It overflows 16 bits exactly when v / 64 >= base;
        // otherwise v / 64 is a valid starting remainder.
        for (j = 0; j < 3; j++) begin
            p2_next[0].ovf[j] = v[j][NUM_W-1:6] >= {4'd0, base_w[RATIO_W-1:0]};
            p2_next[0].rem[j] = v[j][RATIO_W+5:6];
            p2_next[0].num[j] = {v[j][5:0], 10'd0};
        end

        for (k = 1; k <= P2_STAGES; k++) begin
            p2_next[k] = p2_reg[k-1];
            for (j = 0; j < 3; j++) begin
                st = div_step(p2_reg[k-1].rem[j], p2_reg[k-1].num[j][GAIN_W-1 -: STEP_W],
                              p2_reg[k-1].base);
                p2_next[k].rem[j] = st[RATIO_W+STEP_W-1:STEP_W];
                p2_next[k].quo[j] = {p2_reg[k-1].quo[j][GAIN_W-STEP_W-1:0], st[STEP_W-1:0]};
                p2_next[k].num[j] = {p2_reg[k-1].num[j][GAIN_W-STEP_W-1:0], {STEP_W{1'b0}}};
            end
        end

        ovf = p2_reg[P2_STAGES].ovf;
        for (j = 0; j < 3; j++) begin
            g = ovf[j] ? GAIN_MAX : p2_reg[P2_STAGES].quo[j];
            gain_next[j]  = p2_reg[P2_STAGES].fault ? '0 : g;
            apply_next[j] = !p2_reg[P2_STAGES].fault && (g > UNITY_GAIN);
        end
        clip_next    = !p2_reg[P2_STAGES].fault && (ovf != '0);
        fault_next   = p2_reg[P2_STAGES].fault;
        missing_next = p2_reg[P2_STAGES].missing;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg  <= '0;
            p2_valid_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            p1_valid_reg  <= {p1_valid_reg[P1_STAGES-1:0], s_valid};
            p2_valid_reg  <= {p2_valid_reg[P2_STAGES-1:0], p1_valid_reg[P1_STAGES]};
            out_valid_reg <= p2_valid_reg[P2_STAGES];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k <= P1_STAGES; k++) begin
                p1_reg[k] <= p1_next[k];
            end
            for (int k = 0; k <= P2_STAGES; k++) begin
                p2_reg[k] <= p2_next[k];
            end
            gain_reg    <= gain_next;
            apply_reg   <= apply_next;
            clip_reg    <= clip_next;
            fault_reg   <= fault_next;
            missing_reg <= missing_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_red_gain       = gain_reg[0];
    assign m_green_gain     = gain_reg[1];
    assign m_blue_gain      = gain_reg[2];
    assign m_red_apply      = apply_reg[0];
    assign m_green_apply    = apply_reg[1];
    assign m_blue_apply     = apply_reg[2];
    assign m_gain_clipped   = clip_reg;
    assign m_divide_fault   = fault_reg;
    assign m_golden_missing = missing_reg;

    `AWB_ASSERT_NEXT(a_enter, aclk, aresetn, s_valid && s_ready, p1_valid_reg[0])
    `AWB_ASSERT_IMP(a_fault_zero, aclk, aresetn, m_valid && m_divide_fault,
                    m_red_gain == '0 && m_green_gain == '0 && m_blue_gain == '0 && !m_gain_clipped)
    `AWB_ASSERT_IMP(a_clip_max, aclk, aresetn, m_valid && m_gain_clipped,
                    m_red_gain == GAIN_MAX || m_green_gain == GAIN_MAX || m_blue_gain == GAIN_MAX)
    `AWB_ASSERT_IMP(a_apply, aclk, aresetn, m_valid,
                    m_green_apply == (m_green_gain > UNITY_GAIN))

endmodule
